// ----- hdl/tope_pkg.sv -----
package tope_pkg;

    // Widths of the stream payloads, padded to whole bytes, and of the unpadded result
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 80;
    localparam int RESULT_W  = 73;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_KIND_FLAG   = 2'd0;
    localparam cfg_index_t CFG_KIND_TYPE   = 2'd1;
    localparam cfg_index_t CFG_KIND_PUZZLE = 2'd2;
    localparam cfg_index_t CFG_KIND_NONCE  = 2'd3;

    // Reset values of the kind registers
    localparam logic [7:0] KIND_FLAG_RESET   = 8'd10;
    localparam logic [7:0] KIND_TYPE_RESET   = 8'd11;
    localparam logic [7:0] KIND_PUZZLE_RESET = 8'd12;
    localparam logic [7:0] KIND_NONCE_RESET  = 8'd13;

    // Standard option kinds, the shortest legal length and the exact lengths of the recognised options
    localparam logic [7:0] OPT_END  = 8'd0;
    localparam logic [7:0] OPT_NOOP = 8'd1;
    localparam logic [7:0] LEN_MIN  = 8'd2;
    localparam logic [7:0] LEN_FLAG = 8'd2;
    localparam logic [7:0] LEN_TYPE = 8'd3;
    localparam logic [7:0] LEN_WORD = 8'd6;

    // Configured option kinds, handed from the register file to the parser
    typedef struct packed {
        logic [7:0] kind_flag;
        logic [7:0] kind_type;
        logic [7:0] kind_puzzle;
        logic [7:0] kind_nonce;
    } kinds_t;

    // One result; flag_seen sits in the lowest bit
    typedef struct packed {
        logic [31:0] nonce_value;
        logic [31:0] puzzle_value;
        logic [7:0]  type_byte;
        logic        flag_seen;
    } result_t;

    // Parser phase, one-hot
    typedef enum logic [3:0] {
        PH_KIND  = 4'b0001,
        PH_LEN   = 4'b0010,
        PH_VALUE = 4'b0100,
        PH_STOP  = 4'b1000
    } phase_t;

endpackage

// ----- hdl/tope_cfg_regs.sv -----
module tope_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  tope_pkg::cfg_index_t          cfg_index,
    input  logic [tope_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output tope_pkg::kinds_t              kinds
);
    import tope_pkg::*;

    kinds_t kinds_reg;
    kinds_t kinds_next;

    // Decode the register index of a write
    always_comb begin
        kinds_next = kinds_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_KIND_FLAG:   kinds_next.kind_flag   = cfg_wdata;
                CFG_KIND_TYPE:   kinds_next.kind_type   = cfg_wdata;
                CFG_KIND_PUZZLE: kinds_next.kind_puzzle = cfg_wdata;
                CFG_KIND_NONCE:  kinds_next.kind_nonce  = cfg_wdata;
                default:         kinds_next = kinds_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kinds_reg.kind_flag   <= KIND_FLAG_RESET;
            kinds_reg.kind_type   <= KIND_TYPE_RESET;
            kinds_reg.kind_puzzle <= KIND_PUZZLE_RESET;
            kinds_reg.kind_nonce  <= KIND_NONCE_RESET;
        end else begin
            kinds_reg <= kinds_next;
        end
    end

    assign kinds = kinds_reg;

endmodule

// ----- hdl/tope_parser.sv -----
module tope_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        opt_byte,
    input  logic              last,
    input  logic              empty_req,
    input  tope_pkg::kinds_t  kinds,
    output logic              result_valid,
    output tope_pkg::result_t result
);
    import tope_pkg::*;

    phase_t      phase_reg,  phase_next;
    logic [7:0]  kind_reg,   kind_next;
    logic [7:0]  size_reg,   size_next;
    logic [7:0]  left_reg,   left_next;
    logic [31:0] shift_reg,  shift_next;
    logic        flag_reg,   flag_next;
    logic [7:0]  type_reg,   type_next;
    logic [31:0] puzzle_reg, puzzle_next;
    logic [31:0] nonce_reg,  nonce_next;

    logic        commit;
    logic [7:0]  commit_size;
    logic [31:0] commit_shift;

    // Walk one byte of the option area and update the collected values
    always_comb begin
        phase_next   = phase_reg;
        kind_next    = kind_reg;
        size_next    = size_reg;
        left_next    = left_reg;
        shift_next   = shift_reg;
        commit       = 1'b0;
        commit_size  = size_reg;
        commit_shift = shift_reg;

        case (phase_reg)
            PH_KIND: begin
                if (opt_byte == OPT_END) begin
                    phase_next = PH_STOP;
                end else if (opt_byte == OPT_NOOP) begin
                    phase_next = PH_KIND;
                end else if (last) begin
                    // The length byte would be missing
                    phase_next = PH_STOP;
                end else begin
                    kind_next  = opt_byte;
                    phase_next = PH_LEN;
                end
            end
            PH_LEN: begin
                if (opt_byte < LEN_MIN) begin
                    phase_next = PH_STOP;
                end else begin
                    size_next    = opt_byte;
                    left_next    = opt_byte - LEN_MIN;
                    shift_next   = '0;
                    commit_size  = opt_byte;
                    commit_shift = '0;
                    if (opt_byte == LEN_MIN) begin
                        commit     = 1'b1;
                        phase_next = PH_KIND;
                    end else begin
                        phase_next = PH_VALUE;
                    end
                end
            end
            PH_VALUE: begin
                shift_next   = {shift_reg[23:0], opt_byte};
                left_next    = left_reg - 8'd1;
                commit_shift = {shift_reg[23:0], opt_byte};
                if (left_reg == 8'd1) begin
                    commit     = 1'b1;
                    phase_next = PH_KIND;
                end
            end
            default: phase_next = phase_reg;
        endcase
    end

    // Take a completed option when its kind is known and its length exact
    always_comb begin
        flag_next   = flag_reg;
        type_next   = type_reg;
        puzzle_next = puzzle_reg;
        nonce_next  = nonce_reg;
        if (commit) begin
            if (kind_reg == kinds.kind_flag) begin
                if (commit_size == LEN_FLAG) flag_next = 1'b1;
            end else if (kind_reg == kinds.kind_type) begin
                if (commit_size == LEN_TYPE) type_next = commit_shift[7:0];
            end else if (kind_reg == kinds.kind_puzzle) begin
                if (commit_size == LEN_WORD) puzzle_next = commit_shift;
            end else if (kind_reg == kinds.kind_nonce) begin
                if (commit_size == LEN_WORD) nonce_next = commit_shift;
            end
        end
    end

    // An empty request reports what was found so far; a last byte reports after it
    always_comb begin
        result_valid = last || empty_req;
        if (empty_req) begin
            result.flag_seen    = flag_reg;
            result.type_byte    = type_reg;
            result.puzzle_value = puzzle_reg;
            result.nonce_value  = nonce_reg;
        end else begin
            result.flag_seen    = flag_next;
            result.type_byte    = type_next;
            result.puzzle_value = puzzle_next;
            result.nonce_value  = nonce_next;
        end
    end

    // Packet state; cleared after every result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_KIND;
            kind_reg   <= '0;
            size_reg   <= '0;
            left_reg   <= '0;
            shift_reg  <= '0;
            flag_reg   <= 1'b0;
            type_reg   <= '0;
            puzzle_reg <= '0;
            nonce_reg  <= '0;
        end else if (step) begin
            if (result_valid) begin
                phase_reg  <= PH_KIND;
                kind_reg   <= '0;
                size_reg   <= '0;
                left_reg   <= '0;
                shift_reg  <= '0;
                flag_reg   <= 1'b0;
                type_reg   <= '0;
                puzzle_reg <= '0;
                nonce_reg  <= '0;
            end else begin
                phase_reg  <= phase_next;
                kind_reg   <= kind_next;
                size_reg   <= size_next;
                left_reg   <= left_next;
                shift_reg  <= shift_next;
                flag_reg   <= flag_next;
                type_reg   <= type_next;
                puzzle_reg <= puzzle_next;
                nonce_reg  <= nonce_next;
            end
        end
    end

endmodule

// ----- hdl/tcp_option_puzzle_extractor.sv -----
// Channel   Direction  Contents
// s_        in         one option byte per request; tlast ends the area, tuser = empty
// m_        out        one result per option area
// cfg_      in         writes of the four option kind registers
//
// A new request can be taken every cycle while m_ is not stalled: the byte is
// registered, parsed by the short logic of the parser and the result registered,
// so a result reaches m_ through the input and result registers.
// Reset (aresetn low, synchronous) clears the parser, both stages and loads
// the default kind numbers 10 to 13.
// A stalled result holds the input stage; once the input register is full as
// well, s_tready follows m_tready.
module tcp_option_puzzle_extractor (
    input  logic                               aclk,
    input  logic                               aresetn,
    // opt_byte [7:0]
    input  logic [tope_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tlast,
    // empty_req [0]
    input  logic                               s_tuser,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // flag_seen [0], type_byte [8:1], puzzle_value [40:9],
    // nonce_value [72:41], zeros [79:73]
    output logic [tope_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_we,
    input  tope_pkg::cfg_index_t               cfg_index,
    input  logic [tope_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import tope_pkg::*;

    kinds_t     kinds;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       in_empty_reg;
    logic       out_valid_reg;
    result_t    out_data_reg;
    logic       advance;
    logic       result_valid;
    result_t    result;

    tope_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .kinds     (kinds)
    );

    // The registered byte moves on when the result stage has room
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata[7:0];
            in_last_reg  <= s_tlast;
            in_empty_reg <= s_tuser;
        end
    end

    tope_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .opt_byte     (in_byte_reg),
        .last         (in_last_reg),
        .empty_req    (in_empty_reg),
        .kinds        (kinds),
        .result_valid (result_valid),
        .result       (result)
    );

    // Result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= advance && result_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && result_valid) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - RESULT_W){1'b0}}, out_data_reg};

endmodule

// ----- tb/tb_tcp_option_puzzle_extractor.sv -----
`timescale 1ns / 100ps

module tb_tcp_option_puzzle_extractor;
    import tope_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 300;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  s_tuser   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_we    = 1'b0;
    cfg_index_t            cfg_index = CFG_KIND_FLAG;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Model of the parser: configured kinds and the state of the current option area.
    kinds_t      kinds = '{kind_flag: KIND_FLAG_RESET, kind_type: KIND_TYPE_RESET,
                           kind_puzzle: KIND_PUZZLE_RESET, kind_nonce: KIND_NONCE_RESET};
    phase_t      opt_phase  = PH_KIND;
    logic [7:0]  cur_kind   = '0;
    logic [7:0]  cur_len    = '0;
    logic [7:0]  bytes_left = '0;
    logic [31:0] word_acc   = '0;
    logic        got_flag   = 1'b0;
    logic [7:0]  got_type   = '0;
    logic [31:0] got_puzzle = '0;
    logic [31:0] got_nonce  = '0;

    // Option summaries still to come out of the block, oldest first.
    result_t pending_results[$];

    int mismatches    = 0;
    int requests_sent = 0;
    int cycle_count   = 0;
    int hold_left     = 0;
    int stall_left    = 0;
    bit source_idling = 1'b1;
    bit sink_idling   = 1'b1;
    bit hold_request  = 1'b0;

    tcp_option_puzzle_extractor dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // A complete option has been seen: keep its value if the kind is known and
    // the length exact. Earlier kinds win when registers hold the same number.
    function automatic void take_option();
        if (cur_kind == kinds.kind_flag) begin
            if (cur_len == LEN_FLAG) got_flag = 1'b1;
        end else if (cur_kind == kinds.kind_type) begin
            if (cur_len == LEN_TYPE) got_type = word_acc[7:0];
        end else if (cur_kind == kinds.kind_puzzle) begin
            if (cur_len == LEN_WORD) got_puzzle = word_acc;
        end else if (cur_kind == kinds.kind_nonce) begin
            if (cur_len == LEN_WORD) got_nonce = word_acc;
        end
    endfunction

    // Advances the model by one request; returns 1 when a summary is due.
    function automatic bit parse_request(input logic [7:0] b, input bit lst, input bit emp,
                                         output result_t res);
        if (!emp) begin
            case (opt_phase)
                PH_KIND: begin
                    if (b == OPT_END || (b != OPT_NOOP && lst)) begin
                        opt_phase = PH_STOP;
                    end else if (b != OPT_NOOP) begin
                        cur_kind  = b;
                        opt_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    if (b < LEN_MIN) begin
                        opt_phase = PH_STOP;
                    end else begin
                        cur_len    = b;
                        bytes_left = b - LEN_MIN;
                        word_acc   = '0;
                        if (bytes_left == 0) begin
                            take_option();
                            opt_phase = PH_KIND;
                        end else begin
                            opt_phase = PH_VALUE;
                        end
                    end
                end
                PH_VALUE: begin
                    word_acc   = {word_acc[23:0], b};
                    bytes_left = bytes_left - 8'd1;
                    if (bytes_left == 0) begin
                        take_option();
                        opt_phase = PH_KIND;
                    end
                end
                default: begin
                end
            endcase
            if (!lst) return 1'b0;
        end
        res.flag_seen    = got_flag;
        res.type_byte    = got_type;
        res.puzzle_value = got_puzzle;
        res.nonce_value  = got_nonce;
        // The next option area starts from scratch.
        opt_phase  = PH_KIND;
        cur_kind   = '0;
        cur_len    = '0;
        bytes_left = '0;
        word_acc   = '0;
        got_flag   = 1'b0;
        got_type   = '0;
        got_puzzle = '0;
        got_nonce  = '0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("cycle %0d: %s mismatch, got %0h expected %0h", cycle_count, what, got, want);
        mismatches++;
    endtask

    // Offers one request after a random gap and waits until it is taken.
    task automatic send_request(input logic [7:0] b, input bit lst, input bit emp);
        int      gap;
        result_t res;
        gap = source_idling ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tdata  <= b;
        s_tlast  <= lst;
        s_tuser  <= emp;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
        if (parse_request(b, lst, emp, res)) pending_results.push_back(res);
    endtask

    // Sends one option area, last marked on its final byte; empty_odds of N puts
    // an empty request on about one byte in N.
    task automatic send_area(input logic [7:0] area[$], input int empty_odds);
        bit emp;
        foreach (area[i]) begin
            emp = (empty_odds != 0) && ($urandom_range(1, empty_odds) == 1);
            send_request(area[i], i == area.size() - 1, emp);
        end
    endtask

    // Builds a random option area. Well-formed areas are chains of options with
    // random content; the others are raw noise, often with a broken length.
    task automatic send_option_area(input bit well_formed);
        logic [7:0] area[$];
        logic [7:0] known[4];
        int         len;
        known = '{kinds.kind_flag, kinds.kind_type, kinds.kind_puzzle, kinds.kind_nonce};
        if (well_formed) begin
            repeat ($urandom_range(1, 5)) begin
                case ($urandom_range(0, 8))
                    0: area.push_back(OPT_NOOP);
                    1: begin
                        area.push_back(known[0]);
                        area.push_back(LEN_FLAG);
                    end
                    2: begin
                        area.push_back(known[1]);
                        area.push_back(LEN_TYPE);
                        area.push_back(8'($urandom_range(0, 255)));
                    end
                    3, 4: begin
                        area.push_back(known[$urandom_range(2, 3)]);
                        area.push_back(LEN_WORD);
                        repeat (4) area.push_back(8'($urandom_range(0, 255)));
                    end
                    5: begin
                        // Known kind carrying a length it should not have.
                        len = $urandom_range(2, 8);
                        area.push_back(known[$urandom_range(0, 3)]);
                        area.push_back(8'(len));
                        repeat (len - 2) area.push_back(8'($urandom_range(0, 255)));
                    end
                    default: begin
                        len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 255)
                                                          : $urandom_range(2, 10);
                        area.push_back(8'($urandom_range(2, 255)));
                        area.push_back(8'(len));
                        repeat ((len - 2 > 12) ? 12 : len - 2)
                            area.push_back(8'($urandom_range(0, 255)));
                    end
                endcase
            end
            // Now and then close with end-of-list and some padding, as real headers do.
            if ($urandom_range(0, 3) == 0) begin
                area.push_back(OPT_END);
                repeat ($urandom_range(0, 3)) area.push_back(8'($urandom_range(0, 255)));
            end
            // Now and then cut the area short, so that its last option may run past the end.
            if ($urandom_range(0, 5) == 0 && area.size() > 1) begin
                repeat ($urandom_range(1, area.size() - 1)) void'(area.pop_back());
            end
        end else begin
            repeat ($urandom_range(1, 12)) area.push_back(8'($urandom_range(0, 255)));
            if (area.size() > 1 && $urandom_range(0, 1) == 0)
                area[1] = 8'($urandom_range(0, 1));
        end
        send_area(area, 40);
    endtask

    // Lets the block drain completely before anything is reconfigured.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic set_kinds(input logic [7:0] flag_k, input logic [7:0] type_k,
                             input logic [7:0] puzzle_k, input logic [7:0] nonce_k);
        cfg_index_t regs[4] = '{CFG_KIND_FLAG, CFG_KIND_TYPE, CFG_KIND_PUZZLE, CFG_KIND_NONCE};
        logic [7:0] vals[4];
        vals = '{flag_k, type_k, puzzle_k, nonce_k};
        settle();
        foreach (regs[i]) begin
            @(negedge aclk);
            cfg_we    <= 1'b1;
            cfg_index <= regs[i];
            cfg_wdata <= vals[i];
        end
        @(negedge aclk);
        cfg_we <= 1'b0;
        kinds = '{kind_flag: flag_k, kind_type: type_k, kind_puzzle: puzzle_k,
                  kind_nonce: nonce_k};
    endtask

    // All four recognised options at the reset kind numbers, with extreme values.
    task automatic test_known_options();
        send_area('{KIND_FLAG_RESET, LEN_FLAG, KIND_TYPE_RESET, LEN_TYPE, 8'hFF,
                    KIND_PUZZLE_RESET, LEN_WORD, 8'hDE, 8'hAD, 8'hBE, 8'hEF}, 0);
        send_area('{KIND_NONCE_RESET, LEN_WORD, 8'h80, 8'h00, 8'h00, 8'h01,
                    OPT_NOOP, OPT_END}, 0);
    endtask

    // Missing length byte, length below two, wrong length, option past the end.
    task automatic test_malformed_options();
        send_request(KIND_TYPE_RESET, 1'b1, 1'b0);
        send_area('{KIND_PUZZLE_RESET, 8'd1, 8'hAA}, 0);
        send_area('{KIND_TYPE_RESET, LEN_FLAG, KIND_PUZZLE_RESET, LEN_WORD, 8'h01}, 0);
    endtask

    // An empty request alone, and one that cuts an area short while last is set.
    task automatic test_empty_requests();
        send_request(8'hFF, 1'b0, 1'b1);
        send_request(KIND_FLAG_RESET, 1'b0, 1'b0);
        send_request(LEN_FLAG, 1'b0, 1'b0);
        send_request(8'h00, 1'b1, 1'b1);
    endtask

    // Several kind settings: end-of-list and no-op numbers, the top of the range,
    // registers that share a number, a random set and finally the defaults.
    task automatic test_kind_registers();
        logic [7:0] settings[6][4];
        int         goal;
        settings = '{'{8'd0, 8'd1, 8'd255, 8'd254}, '{8'd20, 8'd20, 8'd20, 8'd20},
                     '{8'd40, 8'd41, 8'd41, 8'd42}, '{8'd255, 8'd0, 8'd1, 8'd128},
                     '{8'd0, 8'd0, 8'd0, 8'd0},
                     '{KIND_FLAG_RESET, KIND_TYPE_RESET, KIND_PUZZLE_RESET, KIND_NONCE_RESET}};
        for (int i = 0; i < 4; i++) settings[4][i] = 8'($urandom_range(0, 255));
        foreach (settings[s]) begin
            set_kinds(settings[s][0], settings[s][1], settings[s][2], settings[s][3]);
            goal = requests_sent + 120;
            while (requests_sent < goal) send_option_area($urandom_range(0, 4) != 0);
        end
    endtask

    // Bulk random areas; the idling pattern rotates so that some stretches run flat out.
    task automatic test_random_areas();
        int goal;
        int areas;
        goal  = requests_sent + 600;
        areas = 0;
        while (requests_sent < goal) begin
            source_idling = ((areas / 25) % 4) inside {0, 2};
            sink_idling   = ((areas / 25) % 4) inside {0, 3};
            send_option_area($urandom_range(0, 4) != 0);
            areas++;
        end
        source_idling = 1'b1;
        sink_idling   = 1'b1;
    endtask

    // The receiver stops for a long while as requests keep coming, so the block
    // fills up and has to hold its input.
    task automatic test_backpressure();
        int goal;
        source_idling = 1'b0;
        sink_idling   = 1'b0;
        hold_request  = 1'b1;
        goal = requests_sent + 130;
        while (requests_sent < goal) send_option_area(1'b1);
        source_idling = 1'b1;
        sink_idling   = 1'b1;
    endtask

    // Receiver: random stalls, plus the long hold when one is asked for.
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            stall_left = sink_idling ? pick_gap() : 0;
            m_tready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
        end
    end

    // Each summary that leaves the block is checked against the oldest one predicted.
    always @(posedge aclk) begin
        result_t seen;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen = result_t'(m_tdata[RESULT_W-1:0]);
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, nonce_value", seen.nonce_value, '0);
            end else begin
                want = pending_results.pop_front();
                if (seen.flag_seen !== want.flag_seen)
                    report_mismatch("flag_seen", 32'(seen.flag_seen), 32'(want.flag_seen));
                if (seen.type_byte !== want.type_byte)
                    report_mismatch("type_byte", 32'(seen.type_byte), 32'(want.type_byte));
                if (seen.puzzle_value !== want.puzzle_value)
                    report_mismatch("puzzle_value", seen.puzzle_value, want.puzzle_value);
                if (seen.nonce_value !== want.nonce_value)
                    report_mismatch("nonce_value", seen.nonce_value, want.nonce_value);
            end
            if (m_tdata[M_TDATA_W-1:RESULT_W] !== '0)
                report_mismatch("padding", 32'(m_tdata[M_TDATA_W-1:RESULT_W]), '0);
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        test_known_options();
        test_malformed_options();
        test_empty_requests();
        test_kind_registers();
        test_random_areas();
        test_backpressure();
        settle();
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/tope_pkg.sv
hdl/tope_cfg_regs.sv
hdl/tope_parser.sv
hdl/tcp_option_puzzle_extractor.sv
tb/tb_tcp_option_puzzle_extractor.sv
